[design/aad_pkg.sv]
// shared constants and types of the area average downscaler
`default_nettype none
package aad_pkg;

  localparam int unsigned STEP_W    = 21;
  localparam int unsigned SIZE_W    = 13;
  localparam int unsigned BCNT_W    = 3;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned SMP_W     = 8;
  localparam int unsigned POS_W     = 12;
  localparam int unsigned CFG_W     = 21;
  localparam int unsigned ONE_FIX   = 65536;
  localparam int unsigned OUT_BANDS = 4;
  localparam int unsigned ROW_LIMIT = 4096;

  localparam int unsigned MAX_WIDTH_DEF = 4096;
  localparam int unsigned MAX_BLOCK_DEF = 16;
  localparam int unsigned BANDS_DEF     = 4;

  typedef enum logic [2:0] {
    CFG_X_STEP     = 3'd0,
    CFG_Y_STEP     = 3'd1,
    CFG_SRC_WIDTH  = 3'd2,
    CFG_SRC_HEIGHT = 3'd3,
    CFG_DST_WIDTH  = 3'd4,
    CFG_DST_HEIGHT = 3'd5,
    CFG_BAND_COUNT = 3'd6
  } cfg_idx_e;

endpackage
`default_nettype wire

[design/aad_divider.sv]
// restoring divider, one quotient bit per cycle
`default_nettype none
module aad_divider #(
  parameter int unsigned DW = 29,
  parameter int unsigned VW = 21
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [VW-1:0] divisor_i,
  output logic               done_o,
  output logic [DW-1:0]      quo_o,
  output logic [VW-1:0]      rem_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [DW-1:0] quo_q, quo_d;
  logic [VW-1:0] rem_q, rem_d, div_q;
  logic [VW:0]   trial, diff;
  logic          ge;

  always_comb begin
    trial = {rem_q, quo_q[DW-1]};
    diff  = trial - {1'b0, div_q};
    ge    = trial >= {1'b0, div_q};
    rem_d = ge ? diff[VW-1:0] : trial[VW-1:0];
    quo_d = {quo_q[DW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

[design/aad_col_mem.sv]
// per-column partial sum memory, one write and one registered read port
`default_nettype none
module aad_col_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 73
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[design/area_average_downscaler_unit.sv]
// top level of the area average downscaler
// a skipped item leaves the unit idle; any other runs the index divide, then goes back to idle
// if its block is outside the destination, else zeroes the columns between the fill mark and
// its column, updates memory and returns to idle or, if it closes a block, runs the mean divide
// one item in work at a time; a held output result stalls input only while the next mean waits
// reset clears positions and the fill mark and presets config; columns past the mark read as zero
`default_nettype none
module area_average_downscaler_unit #(
  parameter int unsigned MAX_WIDTH = aad_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_BLOCK = aad_pkg::MAX_BLOCK_DEF,
  parameter int unsigned BANDS     = aad_pkg::BANDS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [2:0]                cfg_idx_i,
  input  wire logic [aad_pkg::CFG_W-1:0] cfg_data_i,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic                      frame_start_i,
  input  wire logic [aad_pkg::SMP_W-1:0] sample_0_i,
  input  wire logic [aad_pkg::SMP_W-1:0] sample_1_i,
  input  wire logic [aad_pkg::SMP_W-1:0] sample_2_i,
  input  wire logic [aad_pkg::SMP_W-1:0] sample_3_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [aad_pkg::SMP_W-1:0]      mean_0_o,
  output logic [aad_pkg::SMP_W-1:0]      mean_1_o,
  output logic [aad_pkg::SMP_W-1:0]      mean_2_o,
  output logic [aad_pkg::SMP_W-1:0]      mean_3_o,
  output logic [aad_pkg::POS_W-1:0]      dest_x_o,
  output logic [aad_pkg::POS_W-1:0]      dest_y_o,
  output logic                           frame_end_o
);
  import aad_pkg::*;

  localparam int unsigned LANES    = (BANDS < OUT_BANDS) ? BANDS : OUT_BANDS;
  localparam int unsigned AW       = $clog2(MAX_WIDTH);
  localparam int unsigned CNT_W    = $clog2(MAX_BLOCK * MAX_BLOCK + 1);
  localparam int unsigned SUM_W    = $clog2(255 * MAX_BLOCK * MAX_BLOCK + 1);
  localparam int unsigned ENT_W    = LANES * SUM_W + CNT_W;
  localparam int unsigned STEP_LIM = MAX_BLOCK * ONE_FIX;
  localparam int unsigned QW       = SIZE_W + FRAC_W;
  localparam int unsigned PW       = SIZE_W + STEP_W;
  localparam int unsigned CW       = PW - FRAC_W + 1;
  localparam int unsigned MDW      = SUM_W + 2;
  localparam int unsigned MVW      = CNT_W + 1;

  typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_CLR, ST_MOD, ST_MDIV, ST_OUT} state_e;

  // configuration
  logic [STEP_W-1:0] x_step_q, y_step_q;
  logic [SIZE_W-1:0] src_width_q, src_height_q, dst_width_q, dst_height_q;
  logic [BCNT_W-1:0] band_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_step_q     <= STEP_W'(ONE_FIX);
      y_step_q     <= STEP_W'(ONE_FIX);
      src_width_q  <= SIZE_W'(4096);
      src_height_q <= SIZE_W'(4096);
      dst_width_q  <= SIZE_W'(4096);
      dst_height_q <= SIZE_W'(4096);
      band_count_q <= BCNT_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_X_STEP:     x_step_q     <= cfg_data_i[STEP_W-1:0];
        CFG_Y_STEP:     y_step_q     <= cfg_data_i[STEP_W-1:0];
        CFG_SRC_WIDTH:  src_width_q  <= cfg_data_i[SIZE_W-1:0];
        CFG_SRC_HEIGHT: src_height_q <= cfg_data_i[SIZE_W-1:0];
        CFG_DST_WIDTH:  dst_width_q  <= cfg_data_i[SIZE_W-1:0];
        CFG_DST_HEIGHT: dst_height_q <= cfg_data_i[SIZE_W-1:0];
        CFG_BAND_COUNT: band_count_q <= cfg_data_i[BCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective settings
  logic [SIZE_W-1:0] w, h, dw, dh;
  logic [STEP_W-1:0] xs, ys;
  logic [BCNT_W-1:0] nb1, nb;

  always_comb begin
    w   = (src_width_q == '0) ? SIZE_W'(1) : src_width_q;
    h   = (src_height_q == '0) ? SIZE_W'(1) : src_height_q;
    dw  = (32'(dst_width_q) > MAX_WIDTH) ? SIZE_W'(MAX_WIDTH) : dst_width_q;
    dh  = (dst_height_q > SIZE_W'(ROW_LIMIT)) ? SIZE_W'(ROW_LIMIT) : dst_height_q;
    xs  = (32'(x_step_q) > STEP_LIM) ? STEP_W'(STEP_LIM) : x_step_q;
    ys  = (32'(y_step_q) > STEP_LIM) ? STEP_W'(STEP_LIM) : y_step_q;
    nb1 = (band_count_q > BCNT_W'(OUT_BANDS)) ? BCNT_W'(OUT_BANDS) : band_count_q;
    nb  = (32'(nb1) > LANES) ? BCNT_W'(LANES) : nb1;
  end

  // covered extent, from configuration only
  logic [PW-1:0] prod_x_q, prod_y_q;
  logic [PW:0]   rnd_x, rnd_y;
  logic [CW-1:0] cov_x, cov_y;

  always_ff @(posedge clk_i) begin
    prod_x_q <= PW'(dw) * PW'(xs);
    prod_y_q <= PW'(dh) * PW'(ys);
  end

  always_comb begin
    rnd_x = {1'b0, prod_x_q} + (PW + 1)'(ONE_FIX - 1);
    rnd_y = {1'b0, prod_y_q} + (PW + 1)'(ONE_FIX - 1);
    cov_x = (rnd_x[PW:FRAC_W] > CW'(w)) ? CW'(w) : rnd_x[PW:FRAC_W];
    cov_y = (rnd_y[PW:FRAC_W] > CW'(h)) ? CW'(h) : rnd_y[PW:FRAC_W];
  end

  // source position
  state_e            state_q;
  logic [SIZE_W-1:0] col_q, row_q, sx_q, sy_q, sx, sy;
  logic [SMP_W-1:0]  smp_q [OUT_BANDS];
  logic [BCNT_W-1:0] nb_q;
  logic [AW:0]       fill_q;
  logic              accept, skip;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign sx         = frame_start_i ? '0 : col_q;
  assign sy         = frame_start_i ? '0 : row_q;
  assign skip       = (sy >= h) || (sx >= w) || (xs == '0) || (ys == '0);

  // index dividers
  logic          idx_done, idy_done;
  logic [QW-1:0] qx, qy;
  logic [STEP_W-1:0] rx, ry;

  aad_divider #(.DW(QW), .VW(STEP_W)) u_div_x (
    .clk_i, .rst_ni,
    .start_i    (accept && !skip),
    .dividend_i ({sx, FRAC_W'(0)}),
    .divisor_i  (xs),
    .done_o     (idx_done),
    .quo_o      (qx),
    .rem_o      (rx)
  );

  aad_divider #(.DW(QW), .VW(STEP_W)) u_div_y (
    .clk_i, .rst_ni,
    .start_i    (accept && !skip),
    .dividend_i ({sy, FRAC_W'(0)}),
    .divisor_i  (ys),
    .done_o     (idy_done),
    .quo_o      (qy),
    .rem_o      (ry)
  );

  // column memory
  logic [AW-1:0]    jaddr, waddr;
  logic [ENT_W-1:0] rdata, ent, wdata;
  logic             mem_we;

  assign jaddr = qx[AW-1:0];
  assign waddr = (state_q == ST_CLR) ? fill_q[AW-1:0] : jaddr;

  aad_col_mem #(.DEPTH(MAX_WIDTH), .WIDTH(ENT_W)) u_mem (
    .clk_i,
    .we_i    (mem_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (jaddr),
    .rdata_o (rdata)
  );

  // read-modify-write
  logic [SUM_W-1:0] sum_new [LANES];
  logic [CNT_W-1:0] cnt_new;
  logic             col_end, row_end, emit, blk_ok;
  logic [AW:0]      jp1;

  always_comb begin
    ent     = ({1'b0, jaddr} < fill_q) ? rdata : '0;
    cnt_new = ent[CNT_W-1:0] + CNT_W'(1);
    for (int b = 0; b < LANES; b++) begin
      sum_new[b] = ent[CNT_W + b*SUM_W +: SUM_W];
      if (32'(b) < 32'(nb_q)) begin
        sum_new[b] = sum_new[b] + SUM_W'(smp_q[b]);
      end
    end
    col_end = ({1'b0, rx} + (STEP_W + 1)'(ONE_FIX) >= {1'b0, xs})
              || ({1'b0, sx_q} + (SIZE_W + 1)'(1) == {1'b0, w});
    row_end = ({1'b0, ry} + (STEP_W + 1)'(ONE_FIX) >= {1'b0, ys})
              || ({1'b0, sy_q} + (SIZE_W + 1)'(1) == {1'b0, h});
    emit    = col_end && row_end;
    wdata   = '0;
    if (!emit && (state_q != ST_CLR)) begin
      wdata[CNT_W-1:0] = cnt_new;
      for (int b = 0; b < LANES; b++) begin
        wdata[CNT_W + b*SUM_W +: SUM_W] = sum_new[b];
      end
    end
    mem_we  = (state_q == ST_MOD) || (state_q == ST_CLR);
    jp1     = {1'b0, jaddr} + (AW + 1)'(1);
    blk_ok  = (qx < QW'(dw)) && (qy < QW'(dh));
  end

  // mean dividers, one per band
  logic             mean_start;
  logic             mdone [LANES];
  logic [MDW-1:0]   mquo [LANES];
  logic [MVW-1:0]   mrem [LANES];
  logic [SMP_W-1:0] mean_v [OUT_BANDS];

  assign mean_start = (state_q == ST_MOD) && emit;

  for (genvar b = 0; b < LANES; b++) begin : g_mean
    aad_divider #(.DW(MDW), .VW(MVW)) u_div_m (
      .clk_i, .rst_ni,
      .start_i    (mean_start),
      .dividend_i (MDW'({sum_new[b], 1'b0}) + MDW'(cnt_new)),
      .divisor_i  ({cnt_new, 1'b0}),
      .done_o     (mdone[b]),
      .quo_o      (mquo[b]),
      .rem_o      (mrem[b])
    );
  end

  for (genvar b = 0; b < OUT_BANDS; b++) begin : g_band
    if (b < LANES) begin : g_used
      assign mean_v[b] = (32'(b) < 32'(nb_q)) ? mquo[b][SMP_W-1:0] : '0;
    end else begin : g_zero
      assign mean_v[b] = '0;
    end
  end

  // control and output register
  logic [POS_W-1:0] dx_q, dy_q, dest_x_q, dest_y_q;
  logic             fe_q, frame_end_q, out_valid_q, out_free, out_load;
  logic [SMP_W-1:0] mean_q [OUT_BANDS];

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = ((state_q == ST_OUT) || (state_q == ST_MDIV && mdone[0])) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (frame_start_i) begin
              fill_q <= '0;
            end
            if ({1'b0, sx} + (SIZE_W + 1)'(1) >= {1'b0, w}) begin
              col_q <= '0;
              if (sy < h) begin
                row_q <= sy + SIZE_W'(1);
              end else begin
                row_q <= sy;
              end
            end else begin
              col_q <= sx + SIZE_W'(1);
              row_q <= sy;
            end
            if (!skip) begin
              state_q <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (idx_done) begin
            if (!blk_ok) begin
              state_q <= ST_IDLE;
            end else if ({1'b0, jaddr} > fill_q) begin
              state_q <= ST_CLR;
            end else begin
              state_q <= ST_MOD;
            end
          end
        end
        ST_CLR: begin
          fill_q <= fill_q + (AW + 1)'(1);
          if (fill_q + (AW + 1)'(1) == {1'b0, jaddr}) begin
            state_q <= ST_MOD;
          end
        end
        ST_MOD: begin
          if (jp1 > fill_q) begin
            fill_q <= jp1;
          end
          state_q <= emit ? ST_MDIV : ST_IDLE;
        end
        ST_MDIV, ST_OUT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end else if (mdone[0]) begin
            state_q <= ST_OUT;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sx_q     <= sx;
      sy_q     <= sy;
      nb_q     <= nb;
      smp_q[0] <= sample_0_i;
      smp_q[1] <= sample_1_i;
      smp_q[2] <= sample_2_i;
      smp_q[3] <= sample_3_i;
    end
    if (state_q == ST_MOD) begin
      dx_q <= qx[POS_W-1:0];
      dy_q <= qy[POS_W-1:0];
      fe_q <= (CW'(sx_q) + CW'(1) == cov_x) && (CW'(sy_q) + CW'(1) == cov_y);
    end
    if (out_load) begin
      mean_q      <= mean_v;
      dest_x_q    <= dx_q;
      dest_y_q    <= dy_q;
      frame_end_q <= fe_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign mean_0_o    = mean_q[0];
  assign mean_1_o    = mean_q[1];
  assign mean_2_o    = mean_q[2];
  assign mean_3_o    = mean_q[3];
  assign dest_x_o    = dest_x_q;
  assign dest_y_o    = dest_y_q;
  assign frame_end_o = frame_end_q;

  a_div_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_done == idy_done)
    else $error("index dividers out of step");

  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_done |-> state_q == ST_DIV)
    else $error("index divide finished outside divide state");

  a_mod_from_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MOD |-> ($past(state_q) == ST_DIV) || ($past(state_q) == ST_CLR))
    else $error("memory update without a finished read");

  a_mean_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mdone[0] |-> state_q == ST_MDIV)
    else $error("mean divide finished outside mean state");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= MAX_WIDTH)
    else $error("fill mark beyond memory depth");

endmodule
`default_nettype wire

[sim/tb_top.sv]
// self-checking testbench for the area average downscaler unit
`timescale 1ns / 1ps
module tb_top;
  import aad_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned ITEM_GOAL   = 1100;
  localparam int unsigned DRAIN_WAIT  = 120;

  typedef struct {
    bit       frame_start;
    bit [7:0] smp [4];
  } pixel_t;

  typedef struct {
    bit [7:0]  mean [4];
    bit [11:0] dx;
    bit [11:0] dy;
    bit        fend;
  } block_avg_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_idx = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic frame_start = 1'b0;
  logic [7:0] sample [4] = '{default: '0};
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] mean_0, mean_1, mean_2, mean_3;
  logic [11:0] dest_x, dest_y;
  logic frame_end;

  pixel_t pending_pixels [$];
  block_avg_t expected_avgs [$];

  // predictor state and register copy
  logic [20:0] x_step_r, y_step_r;
  logic [12:0] src_w_r, src_h_r, dst_w_r, dst_h_r;
  logic [2:0] bands_r;
  int unsigned src_col, src_row;
  int unsigned col_sum [4096][4];
  int unsigned col_cnt [4096];

  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned pixels_sent = 0;
  int unsigned avgs_seen = 0;
  int unsigned phases = 0;
  int unsigned hold_left = 0;
  bit hold_done = 1'b0;
  bit quiet;

  area_average_downscaler_unit dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .frame_start_i(frame_start),
    .sample_0_i(sample[0]), .sample_1_i(sample[1]),
    .sample_2_i(sample[2]), .sample_3_i(sample[3]),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .mean_0_o(mean_0), .mean_1_o(mean_1), .mean_2_o(mean_2), .mean_3_o(mean_3),
    .dest_x_o(dest_x), .dest_y_o(dest_y), .frame_end_o(frame_end)
  );

  always #5 clk = ~clk;

  assign quiet = (cycles > 4000) && (cycles < 12000);

  function automatic void clear_columns();
    foreach (col_cnt[k]) begin
      col_cnt[k] = 0;
      for (int b = 0; b < 4; b++) col_sum[k][b] = 0;
    end
  endfunction

  function automatic longint unsigned clip_step(logic [20:0] s);
    return (s > MAX_BLOCK_DEF * ONE_FIX) ? MAX_BLOCK_DEF * ONE_FIX : s;
  endfunction

  function automatic longint unsigned span(longint unsigned nblk, longint unsigned st,
                                           longint unsigned sz);
    longint unsigned c;
    c = (nblk * st + ONE_FIX - 1) >> FRAC_W;
    return (c > sz) ? sz : c;
  endfunction

  function automatic void average_pixel(pixel_t p);
    longint unsigned w, h, dw, dh, xs, ys, sx, sy, j, i, n;
    int unsigned nb;
    bit col_end, row_end;
    block_avg_t r;
    w  = (src_w_r == 0) ? 1 : src_w_r;
    h  = (src_h_r == 0) ? 1 : src_h_r;
    dw = (dst_w_r > 4096) ? 4096 : dst_w_r;
    dh = (dst_h_r > ROW_LIMIT) ? ROW_LIMIT : dst_h_r;
    xs = clip_step(x_step_r);
    ys = clip_step(y_step_r);
    nb = (bands_r > 4) ? 4 : bands_r;
    if (p.frame_start) begin
      src_col = 0;
      src_row = 0;
      clear_columns();
    end
    sx = src_col;
    sy = src_row;
    if (sx + 1 >= w) begin
      src_col = 0;
      if (sy < h) src_row = sy + 1;
    end else begin
      src_col = sx + 1;
    end
    if (sy >= h || sx >= w || xs == 0 || ys == 0) return;
    j = (sx << FRAC_W) / xs;
    i = (sy << FRAC_W) / ys;
    if (j >= dw || i >= dh) return;
    for (int b = 0; b < nb; b++) col_sum[j][b] += p.smp[b];
    col_cnt[j]++;
    col_end = ((sx + 1) << FRAC_W) >= (j + 1) * xs || sx + 1 == w;
    row_end = ((sy + 1) << FRAC_W) >= (i + 1) * ys || sy + 1 == h;
    if (!(col_end && row_end)) return;
    n = col_cnt[j];
    for (int b = 0; b < 4; b++)
      r.mean[b] = (b < nb && n != 0) ? 8'((longint'(col_sum[j][b]) * 2 + n) / (2 * n)) : 8'd0;
    r.dx = j[11:0];
    r.dy = i[11:0];
    r.fend = (sx + 1 == span(dw, xs, w)) && (sy + 1 == span(dh, ys, h));
    expected_avgs.push_back(r);
    for (int b = 0; b < 4; b++) col_sum[j][b] = 0;
    col_cnt[j] = 0;
  endfunction

  // item driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        average_pixel(pending_pixels.pop_front());
        pixels_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_pixels.size() > 0 && (quiet || $urandom_range(0, 99) >= 30)) begin
          in_valid <= 1'b1;
          frame_start <= pending_pixels[0].frame_start;
          for (int b = 0; b < 4; b++) sample[b] <= pending_pixels[0].smp[b];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    block_avg_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        avgs_seen++;
        if (expected_avgs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected item: x=%0d y=%0d means=%0d %0d %0d %0d end=%0b",
                     dest_x, dest_y, mean_0, mean_1, mean_2, mean_3, frame_end);
        end else begin
          e = expected_avgs.pop_front();
          if (e.mean[0] !== mean_0 || e.mean[1] !== mean_1 || e.mean[2] !== mean_2 ||
              e.mean[3] !== mean_3 || e.dx !== dest_x || e.dy !== dest_y ||
              e.fend !== frame_end) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: exp x=%0d y=%0d m=%0d %0d %0d %0d end=%0b",
                       e.dx, e.dy, e.mean[0], e.mean[1], e.mean[2], e.mean[3], e.fend);
              $display("          got x=%0d y=%0d m=%0d %0d %0d %0d end=%0b",
                       dest_x, dest_y, mean_0, mean_1, mean_2, mean_3, frame_end);
            end
          end
        end
      end
    end
  end

  // receiver stalls, with one long hold counted here
  always @(posedge clk) begin
    if (rst_n) begin
      if (!hold_done && avgs_seen >= 40) begin
        hold_done <= 1'b1;
        hold_left <= 400;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && $urandom_range(0, 99) < 30;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("area_average_downscaler_unit verification failed");
      $finish;
    end
  end

  task automatic wait_idle();
    wait (pending_pixels.size() == 0 && !in_valid);
    @(posedge clk);
    while (in_stall || expected_avgs.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    case (idx)
      CFG_X_STEP:     x_step_r = val[20:0];
      CFG_Y_STEP:     y_step_r = val[20:0];
      CFG_SRC_WIDTH:  src_w_r = val[12:0];
      CFG_SRC_HEIGHT: src_h_r = val[12:0];
      CFG_DST_WIDTH:  dst_w_r = val[12:0];
      CFG_DST_HEIGHT: dst_h_r = val[12:0];
      CFG_BAND_COUNT: bands_r = val[2:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_geometry(int unsigned xs, int unsigned ys, int unsigned sw,
                              int unsigned sh, int unsigned dw, int unsigned dh,
                              int unsigned bc);
    wait_idle();
    write_reg(CFG_X_STEP, xs);
    write_reg(CFG_Y_STEP, ys);
    write_reg(CFG_SRC_WIDTH, sw);
    write_reg(CFG_SRC_HEIGHT, sh);
    write_reg(CFG_DST_WIDTH, dw);
    write_reg(CFG_DST_HEIGHT, dh);
    write_reg(CFG_BAND_COUNT, bc);
    phases++;
  endtask

  task automatic queue_pixels(int unsigned count, bit start_flag, int unsigned fixed);
    pixel_t p;
    for (int k = 0; k < count; k++) begin
      p.frame_start = (k == 0) ? start_flag : ($urandom_range(0, 199) == 0);
      for (int b = 0; b < 4; b++)
        p.smp[b] = (fixed < 256) ? 8'(fixed) : 8'($urandom);
      pending_pixels.push_back(p);
    end
  endtask

  initial begin
    int unsigned xs, ys, sw, sh, dw, dh, bc, npix, queued;
    x_step_r = ONE_FIX;
    y_step_r = ONE_FIX;
    src_w_r = 4096;
    src_h_r = 4096;
    dst_w_r = 4096;
    dst_h_r = 4096;
    bands_r = 1;
    src_col = 0;
    src_row = 0;
    clear_columns();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // values after reset, extreme samples
    queue_pixels(2, 1'b1, 0);
    queue_pixels(2, 1'b0, 255);
    // 2x2 blocks with rounding over all bands
    set_geometry(2 * ONE_FIX, 2 * ONE_FIX, 4, 2, 2, 1, 4);
    queue_pixels(4, 1'b1, 255);
    queue_pixels(4, 1'b0, 1);
    // largest step, zero sizes, zero step, wide destination
    set_geometry(21'h1FFFFF, ONE_FIX, 20, 1, 2, 1, 7);
    queue_pixels(20, 1'b1, 300);
    set_geometry(ONE_FIX, 0, 0, 0, 8191, 8191, 0);
    queue_pixels(3, 1'b1, 300);
    set_geometry(ONE_FIX / 2, ONE_FIX, 3, 2, 0, 2, 2);
    queue_pixels(4, 1'b1, 300);
    queued = 39;

    while (queued < ITEM_GOAL) begin
      case ($urandom_range(0, 9))
        0: xs = 0;
        1: xs = $urandom_range(16 * ONE_FIX, 21'h1FFFFF);
        2: xs = $urandom_range(1, ONE_FIX - 1);
        default: xs = $urandom_range(ONE_FIX, 4 * ONE_FIX);
      endcase
      case ($urandom_range(0, 9))
        0: ys = 0;
        1: ys = $urandom_range(16 * ONE_FIX, 21'h1FFFFF);
        2: ys = $urandom_range(1, ONE_FIX - 1);
        default: ys = $urandom_range(ONE_FIX, 3 * ONE_FIX);
      endcase
      sw = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 1) * 8191 : $urandom_range(1, 24);
      sh = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 8);
      dw = (xs == 0) ? 4 : ((longint'(sw) << FRAC_W) + xs - 1) / xs;
      dh = (ys == 0) ? 4 : ((longint'(sh) << FRAC_W) + ys - 1) / ys;
      if ($urandom_range(0, 9) == 0) dw = $urandom_range(0, 1) * 8191;
      if ($urandom_range(0, 9) == 0) dh = $urandom_range(0, 8191);
      bc = $urandom_range(0, 7);
      set_geometry(xs, ys, sw, sh, dw, dh, bc);
      repeat ($urandom_range(1, 3)) begin
        npix = ((sw == 0) ? 1 : sw) * ((sh == 0) ? 1 : sh);
        if (npix > 200) npix = $urandom_range(1, 40);
        if ($urandom_range(0, 6) == 0) npix = $urandom_range(1, npix + 8);
        queue_pixels(npix, $urandom_range(0, 9) != 0, 300);
        queued += npix;
      end
    end

    wait_idle();
    $display("run: %0d source pixels in %0d register settings, %0d averaged pixels checked",
             pixels_sent, phases, avgs_seen);
    $display("steps from zero to beyond the block limit, all band counts, clipped sizes");
    if (mismatches == 0) begin
      $display("area_average_downscaler_unit verification clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("area_average_downscaler_unit verification failed");
    end
    $finish;
  end

endmodule
